FILE: sv/lfd_pkg.sv
package lfd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int DW         = DATA_WIDTH;
  localparam int SQ_W       = 2 * DW;
  localparam int PROD_W     = 3 * DW;
  localparam int LANES      = 3;
  localparam int DIR_FRAC   = 30;
  localparam int FRAC_BITS  = 16;
  localparam int ROOT_STEPS = SQ_W / 2;
  localparam int DIV_STEPS  = DW;
  localparam int ADDR_W     = 3;
  localparam int REG_IDX_W  = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_CHARGE_COEF = '0;

  typedef struct packed {
    logic signed [DW-1:0] mom_x;
    logic signed [DW-1:0] mom_y;
    logic signed [DW-1:0] mom_z;
    logic signed [DW-1:0] field_x;
    logic signed [DW-1:0] field_y;
    logic signed [DW-1:0] field_z;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] dir_x;
    logic signed [DW-1:0] dir_y;
    logic signed [DW-1:0] dir_z;
    logic signed [DW-1:0] dmom_x;
    logic signed [DW-1:0] dmom_y;
    logic signed [DW-1:0] dmom_z;
    logic                 zero_momentum;
  } out_t;

  // Per-request data carried alongside the square root.
  typedef struct packed {
    logic [LANES-1:0][DW-1:0]     pmag;
    logic [LANES-1:0]             pneg;
    logic [LANES-1:0][PROD_W-1:0] prod;
    logic [LANES-1:0]             dneg;
    logic                         zero;
  } side_t;

endpackage

FILE: sv/lfd_front.sv
module lfd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         req_valid,
  input  lfd_pkg::in_t                 req,
  input  logic [lfd_pkg::DW-1:0]       coef,
  output logic                         sum_valid,
  output logic [lfd_pkg::SQ_W-1:0]     sum_sq,
  output lfd_pkg::side_t               side
);
  import lfd_pkg::*;

  logic signed [DW-1:0] mom [LANES];
  logic signed [DW-1:0] fld [LANES];

  assign mom[0] = req.mom_x;
  assign mom[1] = req.mom_y;
  assign mom[2] = req.mom_z;
  assign fld[0] = req.field_x;
  assign fld[1] = req.field_y;
  assign fld[2] = req.field_z;

  // stage 1: products
  logic                        v1;
  logic [SQ_W-1:0]             sq1 [LANES];
  logic signed [SQ_W-1:0]      cr1 [2*LANES];
  logic [LANES-1:0][DW-1:0]    pmag1;
  logic [LANES-1:0]            pneg1;
  logic                        zero1;

  // stage 2: sum of squares, cross product magnitudes
  logic                        v2;
  logic [SQ_W-1:0]             s2;
  logic [SQ_W-1:0]             cm2 [LANES];
  logic [LANES-1:0]            dneg2;
  logic [LANES-1:0][DW-1:0]    pmag2;
  logic [LANES-1:0]            pneg2;
  logic                        zero2;

  // stage 3: partial products with the coefficient
  logic                        v3;
  logic [SQ_W-1:0]             s3;
  logic [SQ_W-1:0]             plo3 [LANES];
  logic [SQ_W-1:0]             phi3 [LANES];
  logic [LANES-1:0]            dneg3;
  logic [LANES-1:0][DW-1:0]    pmag3;
  logic [LANES-1:0]            pneg3;
  logic                        zero3;

  // stage 4: full product
  logic                        v4;
  logic [SQ_W-1:0]             s4;
  logic [LANES-1:0][PROD_W-1:0] prod4;
  logic [LANES-1:0]            dneg4;
  logic [LANES-1:0][DW-1:0]    pmag4;
  logic [LANES-1:0]            pneg4;
  logic                        zero4;

  logic [DW-1:0]               km;
  logic                        kneg;
  logic [SQ_W:0]               diff [LANES];
  logic [SQ_W:0]               dmag [LANES];

  assign kneg = coef[DW-1];
  assign km   = kneg ? (~coef + 1'b1) : coef;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      diff[i] = {cr1[2*i][SQ_W-1], cr1[2*i]} - {cr1[2*i+1][SQ_W-1], cr1[2*i+1]};
      dmag[i] = diff[i][SQ_W] ? (~diff[i] + 1'b1) : diff[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= req_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        sq1[i]   <= mom[i] * mom[i];
        pmag1[i] <= mom[i][DW-1] ? (~mom[i] + 1'b1) : mom[i];
        pneg1[i] <= mom[i][DW-1];
      end
      cr1[0] <= mom[1] * fld[2];
      cr1[1] <= mom[2] * fld[1];
      cr1[2] <= mom[2] * fld[0];
      cr1[3] <= mom[0] * fld[2];
      cr1[4] <= mom[0] * fld[1];
      cr1[5] <= mom[1] * fld[0];
      zero1  <= (mom[0] == '0) && (mom[1] == '0) && (mom[2] == '0);

      s2    <= sq1[0] + sq1[1] + sq1[2];
      for (int i = 0; i < LANES; i++) begin
        cm2[i]   <= dmag[i][SQ_W-1:0];
        dneg2[i] <= diff[i][SQ_W] ^ kneg;
      end
      pmag2 <= pmag1;
      pneg2 <= pneg1;
      zero2 <= zero1;

      s3 <= s2;
      for (int i = 0; i < LANES; i++) begin
        plo3[i] <= cm2[i][DW-1:0] * km;
        phi3[i] <= cm2[i][SQ_W-1:DW] * km;
      end
      dneg3 <= dneg2;
      pmag3 <= pmag2;
      pneg3 <= pneg2;
      zero3 <= zero2;

      s4 <= s3;
      for (int i = 0; i < LANES; i++) begin
        prod4[i] <= PROD_W'(plo3[i]) + {phi3[i], {DW{1'b0}}};
      end
      dneg4 <= dneg3;
      pmag4 <= pmag3;
      pneg4 <= pneg3;
      zero4 <= zero3;
    end
  end

  assign sum_valid  = v4;
  assign sum_sq     = s4;
  assign side.pmag  = pmag4;
  assign side.pneg  = pneg4;
  assign side.prod  = prod4;
  assign side.dneg  = dneg4;
  assign side.zero  = zero4;

endmodule

FILE: sv/lfd_sqrt.sv
module lfd_sqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     sum_valid,
  input  logic [lfd_pkg::SQ_W-1:0] sum_sq,
  input  lfd_pkg::side_t           side_in,
  output logic                     root_valid,
  output logic [lfd_pkg::DW-1:0]   root,
  output lfd_pkg::side_t           side
);
  import lfd_pkg::*;

  localparam int NS    = ROOT_STEPS;
  localparam int REM_W = DW + 3;

  logic              st_v    [NS];
  logic [REM_W-1:0]  st_r    [NS];
  logic [DW-1:0]     st_q    [NS];
  logic [SQ_W-1:0]   st_x    [NS];
  side_t             st_side [NS];

  for (genvar j = 0; j < NS; j++) begin : g_step
    logic             v_in;
    logic [REM_W-1:0] r_in;
    logic [DW-1:0]    q_in;
    logic [SQ_W-1:0]  x_in;
    side_t            s_in;
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (j == 0) begin : g_first
      assign v_in = sum_valid;
      assign r_in = '0;
      assign q_in = '0;
      assign x_in = sum_sq;
      assign s_in = side_in;
    end else begin : g_rest
      assign v_in = st_v[j-1];
      assign r_in = st_r[j-1];
      assign q_in = st_q[j-1];
      assign x_in = st_x[j-1];
      assign s_in = st_side[j-1];
    end

    // bring down two radicand bits, try (root << 2) | 1
    assign r2    = {r_in[REM_W-3:0], x_in[SQ_W-1 -: 2]};
    assign trial = {1'b0, q_in, 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[j] <= 1'b0;
      end else if (adv) begin
        st_v[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[j]    <= ge ? (r2 - trial) : r2;
        st_q[j]    <= {q_in[DW-2:0], ge};
        st_x[j]    <= {x_in[SQ_W-3:0], 2'b00};
        st_side[j] <= s_in;
      end
    end
  end

  assign root_valid = st_v[NS-1];
  assign root       = st_q[NS-1];
  assign side       = st_side[NS-1];

endmodule

FILE: sv/lfd_div.sv
module lfd_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   root_valid,
  input  logic [lfd_pkg::DW-1:0] root,
  input  lfd_pkg::side_t         side,
  output logic                   res_valid,
  output lfd_pkg::out_t          res
);
  import lfd_pkg::*;

  localparam int NS = DIV_STEPS;
  localparam int NL = 2 * LANES;

  typedef struct packed {
    logic [LANES-1:0] ovf;
    logic [LANES-1:0] dneg;
    logic [LANES-1:0] pneg;
    logic             zero;
  } flags_t;

  localparam logic [DW-1:0] SAT_POS = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SAT_NEG = {1'b1, {(DW-1){1'b0}}};

  // numerator set-up: lanes 0..2 direction, 3..5 momentum derivative
  logic [SQ_W-1:0]   nd [LANES];
  logic [PROD_W-1:0] nm [LANES];
  logic [PROD_W-1:0] np [LANES];
  logic [DW-1:0]     r0 [NL];
  logic [DW-1:0]     l0 [NL];
  flags_t            f0;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      nd[i]         = (SQ_W'(side.pmag[i]) << DIR_FRAC) + (SQ_W'(root) >> 1);
      nm[i]         = side.prod[i] + (PROD_W'(root) << (FRAC_BITS - 1));
      np[i]         = nm[i] >> FRAC_BITS;
      r0[i]         = nd[i][SQ_W-1:DW];
      l0[i]         = nd[i][DW-1:0];
      r0[LANES + i] = np[i][SQ_W-1:DW];
      l0[LANES + i] = np[i][DW-1:0];
      f0.ovf[i]     = (np[i][PROD_W-1:DW] >= (PROD_W-DW)'(root));
    end
    f0.dneg = side.dneg;
    f0.pneg = side.pneg;
    f0.zero = side.zero;
  end

  logic          pv;
  logic [DW-1:0] pr [NL];
  logic [DW-1:0] pl [NL];
  logic [DW-1:0] pd;
  flags_t        pf;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (adv) begin
      pv <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr <= r0;
      pl <= l0;
      pd <= root;
      pf <= f0;
    end
  end

  logic          st_v [NS];
  logic [DW-1:0] st_r [NS][NL];
  logic [DW-1:0] st_l [NS][NL];
  logic [DW-1:0] st_d [NS];
  flags_t        st_f [NS];

  for (genvar j = 0; j < NS; j++) begin : g_step
    logic          v_in;
    logic [DW-1:0] r_in [NL];
    logic [DW-1:0] l_in [NL];
    logic [DW-1:0] d_in;
    flags_t        f_in;
    logic [DW:0]   r2 [NL];
    logic [DW-1:0] r_nx [NL];
    logic [DW-1:0] l_nx [NL];

    if (j == 0) begin : g_first
      assign v_in = pv;
      assign r_in = pr;
      assign l_in = pl;
      assign d_in = pd;
      assign f_in = pf;
    end else begin : g_rest
      assign v_in = st_v[j-1];
      assign r_in = st_r[j-1];
      assign l_in = st_l[j-1];
      assign d_in = st_d[j-1];
      assign f_in = st_f[j-1];
    end

    // one restoring step per lane; quotient bits shift in below the numerator
    always_comb begin
      for (int k = 0; k < NL; k++) begin
        r2[k] = {r_in[k], l_in[k][DW-1]};
        if (r2[k] >= {1'b0, d_in}) begin
          r_nx[k] = DW'(r2[k] - {1'b0, d_in});
          l_nx[k] = {l_in[k][DW-2:0], 1'b1};
        end else begin
          r_nx[k] = r2[k][DW-1:0];
          l_nx[k] = {l_in[k][DW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[j] <= 1'b0;
      end else if (adv) begin
        st_v[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[j] <= r_nx;
        st_l[j] <= l_nx;
        st_d[j] <= d_in;
        st_f[j] <= f_in;
      end
    end
  end

  // sign, saturation and the zero-momentum case
  logic [DW-1:0] q [NL];
  logic [DW-1:0] val [NL];
  flags_t        ff;
  out_t          res_next;

  assign ff = st_f[NS-1];

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      q[k] = st_l[NS-1][k];
    end
    for (int i = 0; i < LANES; i++) begin
      val[i] = ff.pneg[i] ? (~q[i] + 1'b1) : q[i];
      if (!ff.dneg[i]) begin
        val[LANES + i] = (ff.ovf[i] || (q[LANES + i] > SAT_POS)) ? SAT_POS : q[LANES + i];
      end else begin
        val[LANES + i] = (ff.ovf[i] || (q[LANES + i] > SAT_NEG)) ? SAT_NEG
                                                                  : (~q[LANES + i] + 1'b1);
      end
    end
    if (ff.zero) begin
      for (int k = 0; k < NL; k++) begin
        val[k] = '0;
      end
    end
    res_next.dir_x         = val[0];
    res_next.dir_y         = val[1];
    res_next.dir_z         = val[2];
    res_next.dmom_x        = val[3];
    res_next.dmom_y        = val[4];
    res_next.dmom_z        = val[5];
    res_next.zero_momentum = ff.zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= st_v[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

endmodule

FILE: sv/lorentz_force_derivative_top.sv
// Lorentz-force equation-of-motion right-hand side. Each request carries a
// momentum p and the field B (signed Q16.16) and returns the unit direction
// p/|p| (signed Q2.30) and k*(p x B)/|p| (signed Q16.16, rounded half away
// from zero, saturated), with k the charge_coef register at byte address 0.
// A zero momentum gives all-zero outputs with zero_momentum set. The block
// takes one request every cycle while no result is held. Its path runs
// through the multiply and sum stages, a 32-stage square-root pipeline
// resolving one root bit per stage, a numerator set-up stage, a 32-stage
// divider producing one quotient bit per stage for all six outputs, and the
// output register. A held result stalls every stage and raises req_stall
// in the same cycle. Write charge_coef only while no request is in flight.
module lorentz_force_derivative_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  lfd_pkg::in_t                req,
  output logic                        res_valid,
  input  logic                        res_stall,
  output lfd_pkg::out_t               res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lfd_pkg::*;

  logic             adv;
  logic [DW-1:0]    charge_coef;
  logic             sum_valid;
  logic [SQ_W-1:0]  sum_sq;
  side_t            front_side;
  logic             root_valid;
  logic [DW-1:0]    root;
  side_t            root_side;

  // advance everything unless a finished result is held
  assign adv       = !res_valid || !res_stall;
  assign req_stall = !adv;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      charge_coef <= '0;
    end else if (psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_CHARGE_COEF)) begin
      charge_coef <= pwdata[DW-1:0];
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_CHARGE_COEF: prdata = 32'(charge_coef);
      default:         prdata = '0;
    endcase
  end

  lfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .req_valid (req_valid),
    .req       (req),
    .coef      (charge_coef),
    .sum_valid (sum_valid),
    .sum_sq    (sum_sq),
    .side      (front_side)
  );

  lfd_sqrt u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .sum_valid  (sum_valid),
    .sum_sq     (sum_sq),
    .side_in    (front_side),
    .root_valid (root_valid),
    .root       (root),
    .side       (root_side)
  );

  lfd_div u_div (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .root_valid (root_valid),
    .root       (root),
    .side       (root_side),
    .res_valid  (res_valid),
    .res        (res)
  );

endmodule

FILE: sv/lfd_checker.sv
module lfd_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_stall,
  input logic          res_valid,
  input logic          res_stall,
  input lfd_pkg::out_t res
);
  import lfd_pkg::*;

  localparam logic signed [DW-1:0] DIR_ONE  = DW'(1) << DIR_FRAC;
  localparam logic signed [DW-1:0] DIR_MONE = -DIR_ONE;

  // a held result stays put
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("held result changed");

  // requests are refused only while a result is held
  assert property (@(posedge clk) disable iff (rst)
    req_stall |-> res_valid && res_stall)
    else $error("request refused without a held result");

  // zero momentum forces every value to zero
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.zero_momentum |->
      res.dir_x == '0 && res.dir_y == '0 && res.dir_z == '0 &&
      res.dmom_x == '0 && res.dmom_y == '0 && res.dmom_z == '0)
    else $error("zero momentum with non-zero output");

  // a unit direction stays within one
  assert property (@(posedge clk) disable iff (rst)
    res_valid |->
      res.dir_x <= DIR_ONE && res.dir_x >= DIR_MONE &&
      res.dir_y <= DIR_ONE && res.dir_y >= DIR_MONE &&
      res.dir_z <= DIR_ONE && res.dir_z >= DIR_MONE)
    else $error("direction component above one");

  // non-zero momentum has a non-zero direction
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.zero_momentum |->
      res.dir_x != '0 || res.dir_y != '0 || res.dir_z != '0)
    else $error("direction lost for non-zero momentum");

endmodule

bind lorentz_force_derivative_top lfd_checker u_lfd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

FILE: dv/tb_lorentz_force_derivative_top.sv
module tb_lorentz_force_derivative_top;
  import lfd_pkg::*;

  localparam int                   CLK_HALF   = 10;
  localparam int                   CYCLE_LIM  = 600000;
  localparam int                   DRAIN_WAIT = 90;
  localparam int                   RAND_ITEMS = 270;
  localparam int                   DIR_ROWS   = 16;
  localparam logic [REG_IDX_W-1:0] REG_SPARE  = 1;

  typedef struct {
    in_t  d;
    bit   typed;
    out_t e;
  } stim_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  in_t               req = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  out_t              res;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  stim_t             stim_q[$];
  stim_t             cur;
  out_t              expect_q[$];
  logic signed [31:0] coef = '0;
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                errors = 0;
  int                cycles = 0;

  lorentz_force_derivative_top i_dut (.*);

  always #CLK_HALF clk = ~clk;

  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] unit_lane(input logic signed [63:0] p, input logic [63:0] m);
    logic [63:0] a;
    logic [63:0] q;
    a = p < 0 ? -p : p;
    q = ((a << DIR_FRAC) + (m >> 1)) / m;
    return p < 0 ? 32'(-q) : 32'(q);
  endfunction

  function automatic logic [31:0] force_lane(input logic signed [65:0] c,
                                             input logic signed [31:0] k,
                                             input logic [63:0] m);
    logic [65:0]  cm;
    logic [32:0]  km;
    logic [127:0] q;
    bit           neg;
    cm  = c < 0 ? -c : c;
    km  = k < 0 ? -33'(k) : 33'(k);
    neg = (c < 0) ^ (k < 0);
    if (cm == 0 || km == 0) return '0;
    q = (128'(cm) * 128'(km) + (128'(m) << 15)) / (128'(m) << 16);
    if (!neg) return q > 128'h7FFF_FFFF ? 32'h7FFF_FFFF : 32'(q);
    return q > 128'h8000_0000 ? 32'h8000_0000 : 32'(-q);
  endfunction

  function automatic out_t lorentz_rhs(input in_t d, input logic signed [31:0] k);
    logic signed [63:0] px, py, pz, bx, by, bz;
    logic [63:0]        s, m;
    out_t               o;
    px = d.mom_x;   py = d.mom_y;   pz = d.mom_z;
    bx = d.field_x; by = d.field_y; bz = d.field_z;
    o = '0;
    s = 64'(px * px) + 64'(py * py) + 64'(pz * pz);
    if (s == 0) begin
      o.zero_momentum = 1'b1;
      return o;
    end
    m = root_floor(s);
    o.dir_x  = unit_lane(px, m);
    o.dir_y  = unit_lane(py, m);
    o.dir_z  = unit_lane(pz, m);
    o.dmom_x = force_lane(66'(py * bz) - 66'(pz * by), k, m);
    o.dmom_y = force_lane(66'(pz * bx) - 66'(px * bz), k, m);
    o.dmom_z = force_lane(66'(px * by) - 66'(py * bx), k, m);
    return o;
  endfunction

  // Request side: hold the payload while stalled, advance otherwise.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (req_valid) expect_q.push_back(cur.typed ? cur.e : lorentz_rhs(cur.d, coef));
      if (stim_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur = stim_q.pop_front();
        req <= cur.d;
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result side.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && res_valid && !res_stall) begin
      if (expect_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        out_t e;
        e = expect_q.pop_front();
        if (res.dir_x !== e.dir_x) report($sformatf("dir_x %h exp %h", res.dir_x, e.dir_x));
        if (res.dir_y !== e.dir_y) report($sformatf("dir_y %h exp %h", res.dir_y, e.dir_y));
        if (res.dir_z !== e.dir_z) report($sformatf("dir_z %h exp %h", res.dir_z, e.dir_z));
        if (res.dmom_x !== e.dmom_x) report($sformatf("dmom_x %h exp %h", res.dmom_x, e.dmom_x));
        if (res.dmom_y !== e.dmom_y) report($sformatf("dmom_y %h exp %h", res.dmom_y, e.dmom_y));
        if (res.dmom_z !== e.dmom_z) report($sformatf("dmom_z %h exp %h", res.dmom_z, e.dmom_z));
        if (res.zero_momentum !== e.zero_momentum)
          report($sformatf("zero_momentum %b exp %b", res.zero_momentum, e.zero_momentum));
      end
    end
    res_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIM) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_CHARGE_COEF) coef = val;
  endtask

  task automatic check_coef();
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b0; penable <= 1'b0; paddr <= {REG_CHARGE_COEF, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== coef) report($sformatf("charge_coef read %h exp %h", prdata, coef));
    psel <= 1'b0; penable <= 1'b0;
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(4))
      0:       return 32'($urandom_range(255)) - 32'd128;
      1:       return '0;
      2:       return 32'($signed($urandom_range(1 << 20))) - 32'sd524288;
      3:       return $urandom() >> $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  task automatic push_row(input logic [31:0] mx, my, mz, fx, fy, fz,
                          input bit typed, input out_t e);
    stim_t s;
    s.d = '{mx, my, mz, fx, fy, fz};
    s.typed = typed;
    s.e = e;
    stim_q.push_back(s);
  endtask

  // Directed table: momentum x/y/z, field x/y/z; expected values typed in
  // only for the zero-momentum rows and the single-axis rows with zero field.
  task automatic load_directed();
    localparam logic [31:0] MX = 32'h7FFF_FFFF;
    localparam logic [31:0] MN = 32'h8000_0000;
    localparam logic [31:0] Q1 = 32'h0001_0000;
    logic [31:0] rows [DIR_ROWS][6];
    bit          row_typed [DIR_ROWS];
    out_t        row_exp [DIR_ROWS];
    out_t        n;
    n = '0;
    rows = '{
      '{0, 0, 0, MX, MN, MX},
      '{0, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 0},
      '{MN, 0, 0, 0, 0, 0},
      '{0, MX, 0, 0, 0, 0},
      '{0, 0, 32'hFFFF_FFFF, 0, 0, 0},
      '{MN, MN, MN, MX, MN, MX},
      '{MX, MX, MX, MN, MN, MN},
      '{MX, MN, MX, MN, MX, MN},
      '{1, 1, 1, MX, MN, MX},
      '{1, 0, 0, 0, MN, MX},
      '{Q1, 0, 0, 0, Q1, 0},
      '{0, Q1, 0, 0, 0, Q1},
      '{3, 4, 0, MN, MN, MN},
      '{MX, 0, 0, MX, MX, MX},
      '{Q1, Q1, Q1, Q1, Q1, Q1}
    };
    row_typed = '{1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    row_exp = '{
      '{0, 0, 0, 0, 0, 0, 1'b1},
      '{0, 0, 0, 0, 0, 0, 1'b1},
      '{32'h4000_0000, 0, 0, 0, 0, 0, 1'b0},
      '{32'hC000_0000, 0, 0, 0, 0, 0, 1'b0},
      '{0, 32'h4000_0000, 0, 0, 0, 0, 1'b0},
      '{0, 0, 32'hC000_0000, 0, 0, 0, 1'b0},
      n, n, n, n, n, n, n, n, n, n
    };
    for (int r = 0; r < DIR_ROWS; r++) begin
      push_row(rows[r][0], rows[r][1], rows[r][2], rows[r][3], rows[r][4], rows[r][5],
               row_typed[r], row_exp[r]);
    end
  endtask

  task automatic drain();
    while (stim_q.size() != 0 || req_valid || expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    logic [31:0] coefs[5];
    int          idles[5];
    int          stalls[5];
    coefs  = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, $urandom()};
    idles  = '{0, 82, 0, 38, 0};
    stalls = '{0, 0, 82, 38, 0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    check_coef();
    for (int ph = 0; ph < 5; ph++) begin
      if (ph != 0) begin
        apb_write(REG_SPARE, $urandom());
        apb_write(REG_CHARGE_COEF, coefs[ph]);
        check_coef();
      end
      idle_pct  = idles[ph];
      stall_pct = stalls[ph];
      load_directed();
      for (int i = 0; i < RAND_ITEMS; i++) begin
        out_t n;
        n = '0;
        push_row(rand_comp(), rand_comp(), rand_comp(),
                 rand_comp(), rand_comp(), rand_comp(), 0, n);
      end
      drain();
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
